// ===== sv/pmag_pkg.sv =====
`default_nettype none
package pmag_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SIDE_BITS = 5;
	localparam int CELL_BITS = 3 * SIDE_BITS;
	localparam int WGT_BITS  = FRAC_BITS + 1;
	localparam int SUM_BITS  = 48;

	typedef logic [WGT_BITS-1:0] wgt_t;
	typedef logic [SUM_BITS-1:0] sum_t;

	typedef enum logic [1:0] {
		KERN_NGP = 2'd0,
		KERN_CIC = 2'd1,
		KERN_TSC = 2'd2,
		KERN_RSV = 2'd3
	} kern_t;

	typedef enum logic [1:0] {
		OP_DEPOSIT = 2'd0,
		OP_READ    = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_KERNEL  = 2'd0,
		CFG_VALUES  = 2'd1,
		CFG_WEIGHTS = 2'd2,
		CFG_NORM    = 2'd3
	} cfg_idx_t;

endpackage
`default_nettype wire

// ===== sv/pmag_axis_unit.sv =====
`default_nettype none
module pmag_axis_unit (
	input  wire logic [1:0]                      scheme,
	input  wire logic [pmag_pkg::FRAC_BITS-1:0]  frac,
	input  wire logic [1:0]                      slot,
	output pmag_pkg::wgt_t                       weight
);
	localparam logic [16:0] KHALF = 17'd1 << (pmag_pkg::FRAC_BITS - 1);
	localparam logic [16:0] KONE  = 17'd1 << pmag_pkg::FRAC_BITS;
	localparam logic [16:0] KHALF3 = 17'd3 << (pmag_pkg::FRAC_BITS - 1);
	localparam logic [35:0] INNER = 36'd3 << (2 * pmag_pkg::FRAC_BITS - 1);

	logic [16:0] f;
	logic        lt, gt, use_inner, is_zero;
	logic [16:0] x;
	logic [35:0] prod, val, rnd;

	assign f  = {1'b0, frac};
	assign lt = f < KHALF;
	assign gt = f > KHALF;

	// One squarer serves every triangular-shaped-cloud weight.
	always_comb begin
		x = '0;
		use_inner = 1'b0;
		is_zero = 1'b0;
		case (slot)
			2'd0: begin
				x = KHALF - f;
				is_zero = !lt;
			end
			2'd1: begin
				if (lt) begin
					x = f;
					use_inner = 1'b1;
				end else begin
					x = KHALF3 - f;
				end
			end
			2'd2: begin
				if (lt) begin
					x = KHALF + f;
				end else if (gt) begin
					x = KONE - f;
					use_inner = 1'b1;
				end else begin
					x = KONE;
				end
			end
			default: begin
				x = f - KHALF;
				is_zero = !gt;
			end
		endcase
	end

	assign prod = {19'd0, x} * {19'd0, x};
	assign val  = use_inner ? (INNER - {prod[34:0], 1'b0}) : prod;
	assign rnd  = (val + {19'd0, KONE}) >> (pmag_pkg::FRAC_BITS + 1);

	always_comb begin
		weight = '0;
		case (scheme)
			pmag_pkg::KERN_CIC: begin
				if (slot == 2'd1)
					weight = KONE - f;
				else if (slot == 2'd2)
					weight = f;
			end
			pmag_pkg::KERN_TSC: begin
				if (!is_zero)
					weight = rnd[16:0];
			end
			default: begin
				if ((slot == 2'd1 && f <= KHALF) || (slot == 2'd2 && f > KHALF))
					weight = KONE;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== sv/particle_mass_assignment_grid_top.sv =====
`default_nettype none
// Mass assignment of particles onto a periodic 32x32x32 grid.
// The input channel (in_valid / in_stall) carries one item: a deposit, a
// read of one cell or a clear of both stores. The output channel (out_valid
// / out_stall) returns exactly one result per item, except opcode three,
// which is dropped. Configuration is to be written through cfg_we / cfg_index /
// cfg_data by the user only while the block is idle; the block does not enforce this.
// A deposit first fills the axis weights in S_PREP (one squarer, one weight per
// cycle) and then walks 64 kernel offsets: each nonzero cell passes S_K, S_M1
// and S_M2 through the shared multiply and read-modify-write path, a zero cell
// only S_K, and each x-y pair adds an S_XY step; a full TSC deposit has at
// most 27 nonzero cells. A read goes through S_RD and then S_DONE.
// A clear sweeps all 32768 cells, one per cycle.
// After reset the same sweep runs before the first item is taken. The block
// takes one item at a time; a finished result sits in the output register
// while the next item is already accepted, and a stalled receiver only holds
// the block once a second result is ready.
module particle_mass_assignment_grid_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [1:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [20:0] pos_x,
	input  wire logic [20:0] pos_y,
	input  wire logic [20:0] pos_z,
	input  wire logic signed [31:0] particle_value,
	input  wire logic [31:0] particle_weight,
	input  wire logic [14:0] cell_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       result_kind,
	output logic signed [47:0] value_sum,
	output logic signed [47:0] norm_sum
);
	localparam int FB = pmag_pkg::FRAC_BITS;
	localparam int SB = pmag_pkg::SIDE_BITS;
	localparam int CB = pmag_pkg::CELL_BITS;
	localparam int CELLS = 1 << CB;
	localparam logic [16:0] KONE = 17'd1 << FB;
	localparam logic [33:0] KHALF34 = 34'd1 << (FB - 1);
	localparam logic [49:0] SAT_MAX = 50'sd140737488355327;
	localparam logic [49:0] SAT_MIN = -50'sd140737488355328;

	typedef enum logic [8:0] {
		S_SWEEP = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_PREP  = 9'b000000100,
		S_XY    = 9'b000001000,
		S_K     = 9'b000010000,
		S_M1    = 9'b000100000,
		S_M2    = 9'b001000000,
		S_RD    = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [1:0] kernel_q;
	logic       use_values_q, use_weights_q, keep_norm_q;

	logic [CB-1:0]  sweep_q;
	logic           clr_reply_q;
	logic [3:0]     prep_q;
	logic [1:0]     a_q, b_q, c_q;
	logic [SB-1:0]  base_q [3];
	logic [FB-1:0]  frac_q [3];
	pmag_pkg::wgt_t w_q [3][4];
	logic           neg_q;
	logic [31:0]    vmag_q, wgt_q;
	logic [47:0]    vw_q;
	logic [16:0]    wxy_q, k_q;
	logic [CB-1:0]  addr_q;
	logic [40:0]    hi_q, lo_q;
	logic [32:0]    nm_q;
	logic [1:0]     kind_q;

	logic [47:0] value_mem [CELLS];
	logic [47:0] norm_mem [CELLS];
	logic [47:0] rd_v_q, rd_n_q;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [47:0] out_v_q, out_n_q;

	// Axis weight unit.
	logic [1:0]     prep_axis;
	pmag_pkg::wgt_t unit_w;
	assign prep_axis = prep_q[3:2];

	pmag_axis_unit u_axis (
		.scheme (kernel_q),
		.frac   (frac_q[prep_axis]),
		.slot   (prep_q[1:0]),
		.weight (unit_w)
	);

	logic accept;
	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;

	// Cell index of the current offset; wrap is a natural overflow.
	logic [SB-1:0] cx, cy, cz;
	logic [CB-1:0] cell_idx;
	assign cx = base_q[0] + {{(SB-2){1'b0}}, a_q} - SB'(1);
	assign cy = base_q[1] + {{(SB-2){1'b0}}, b_q} - SB'(1);
	assign cz = base_q[2] + {{(SB-2){1'b0}}, c_q} - SB'(1);
	assign cell_idx = {cx, cy, cz};

	logic [33:0] kprod;
	logic [16:0] k_now;
	assign kprod = {17'd0, wxy_q} * {17'd0, w_q[2][c_q]} + KHALF34;
	assign k_now = kprod[FB+16:FB];

	logic [33:0] xyprod;
	assign xyprod = {17'd0, w_q[0][a_q]} * {17'd0, w_q[1][b_q]} + KHALF34;

	// Accumulate and saturate.
	logic [47:0] cm;
	logic [49:0] cv, vsum, nsum;
	logic [47:0] vnew, nnew;
	assign cm = (k_q >= KONE) ? vw_q : ({hi_q[39:0], 8'd0} + {23'd0, lo_q[40:16]});
	assign cv = neg_q ? (50'd0 - {2'b00, cm}) : {2'b00, cm};
	assign vsum = {{2{rd_v_q[47]}}, rd_v_q} + cv;
	assign nsum = {{2{rd_n_q[47]}}, rd_n_q} + {17'd0, nm_q};
	assign vnew = ($signed(vsum) > $signed(SAT_MAX)) ? SAT_MAX[47:0] :
		($signed(vsum) < $signed(SAT_MIN)) ? SAT_MIN[47:0] : vsum[47:0];
	assign nnew = ($signed(nsum) > $signed(SAT_MAX)) ? SAT_MAX[47:0] : nsum[47:0];

	// Memory ports.
	logic          mem_we, norm_we;
	logic [CB-1:0] wr_addr, rd_addr;
	logic [47:0]   wr_v, wr_n;
	always_comb begin
		mem_we  = 1'b0;
		norm_we = 1'b0;
		wr_addr = addr_q;
		wr_v    = vnew;
		wr_n    = nnew;
		if (state_q == S_SWEEP) begin
			mem_we  = 1'b1;
			norm_we = 1'b1;
			wr_addr = sweep_q;
			wr_v    = '0;
			wr_n    = '0;
		end else if (state_q == S_M2) begin
			mem_we  = 1'b1;
			norm_we = keep_norm_q;
		end
		if (state_q == S_K)
			rd_addr = cell_idx;
		else
			rd_addr = addr_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			value_mem[wr_addr] <= wr_v;
		rd_v_q <= value_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (norm_we)
			norm_mem[wr_addr] <= wr_n;
		rd_n_q <= norm_mem[rd_addr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q      <= pmag_pkg::KERN_NGP;
			use_values_q  <= 1'b1;
			use_weights_q <= 1'b1;
			keep_norm_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pmag_pkg::CFG_KERNEL:  kernel_q      <= cfg_data;
				pmag_pkg::CFG_VALUES:  use_values_q  <= cfg_data[0];
				pmag_pkg::CFG_WEIGHTS: use_weights_q <= cfg_data[0];
				pmag_pkg::CFG_NORM:    keep_norm_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_q     <= '0;
			clr_reply_q <= 1'b0;
			prep_q      <= '0;
			a_q         <= '0;
			b_q         <= '0;
			c_q         <= '0;
			kind_q      <= pmag_pkg::OP_DEPOSIT;
		end else begin
			unique case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + CB'(1);
					if (sweep_q == CB'(CELLS - 1)) begin
						state_q     <= clr_reply_q ? S_DONE : S_IDLE;
						clr_reply_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						kind_q <= opcode;
						unique case (opcode)
							pmag_pkg::OP_DEPOSIT: begin
								state_q <= S_PREP;
								prep_q  <= '0;
								a_q     <= '0;
								b_q     <= '0;
								c_q     <= '0;
							end
							pmag_pkg::OP_READ:  state_q <= S_RD;
							pmag_pkg::OP_CLEAR: begin
								state_q     <= S_SWEEP;
								sweep_q     <= '0;
								clr_reply_q <= 1'b1;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_PREP: begin
					prep_q <= prep_q + 4'd1;
					if (prep_q == 4'd12)
						state_q <= S_XY;
				end
				S_XY: state_q <= S_K;
				S_K: begin
					if (k_now != '0) begin
						state_q <= S_M1;
					end else begin
						c_q <= c_q + 2'd1;
						if (c_q == 2'd3) begin
							b_q <= b_q + 2'd1;
							if (b_q == 2'd3) begin
								a_q <= a_q + 2'd1;
								state_q <= (a_q == 2'd3) ? S_DONE : S_XY;
							end else begin
								state_q <= S_XY;
							end
						end
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: begin
					c_q <= c_q + 2'd1;
					if (c_q == 2'd3) begin
						b_q <= b_q + 2'd1;
						if (b_q == 2'd3) begin
							a_q <= a_q + 2'd1;
							state_q <= (a_q == 2'd3) ? S_DONE : S_XY;
						end else begin
							state_q <= S_XY;
						end
					end else begin
						state_q <= S_K;
					end
				end
				S_RD: state_q <= S_DONE;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	logic [63:0] vwprod;
	logic [48:0] nmprod;
	assign vwprod = {32'd0, vmag_q} * {32'd0, wgt_q} + 64'd32768;
	assign nmprod = {17'd0, wgt_q} * {32'd0, k_q} + {32'd0, KHALF34[16:0]};

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q[0] <= pos_x[FB+SB-1:FB];
			base_q[1] <= pos_y[FB+SB-1:FB];
			base_q[2] <= pos_z[FB+SB-1:FB];
			frac_q[0] <= pos_x[FB-1:0];
			frac_q[1] <= pos_y[FB-1:0];
			frac_q[2] <= pos_z[FB-1:0];
			neg_q     <= use_values_q && particle_value[31];
			if (!use_values_q)
				vmag_q <= 32'd65536;
			else if (particle_value[31])
				vmag_q <= 32'd0 - particle_value;
			else
				vmag_q <= particle_value;
			wgt_q  <= use_weights_q ? particle_weight : 32'd65536;
			addr_q <= cell_index;
		end
		if (state_q == S_PREP) begin
			if (prep_axis != 2'd3)
				w_q[prep_axis][prep_q[1:0]] <= unit_w;
			vw_q <= vwprod[63:16];
		end
		if (state_q == S_XY)
			wxy_q <= xyprod[FB+16:FB];
		if (state_q == S_K) begin
			k_q    <= k_now;
			addr_q <= cell_idx;
		end
		if (state_q == S_M1) begin
			hi_q <= {17'd0, vw_q[47:24]} * {24'd0, k_q};
			lo_q <= {17'd0, vw_q[23:0]} * {24'd0, k_q} + {24'd0, KHALF34[16:0]};
			nm_q <= nmprod[FB+32:FB];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_DONE && out_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_kind_q <= kind_q;
			if (kind_q == pmag_pkg::OP_READ) begin
				out_v_q <= rd_v_q;
				out_n_q <= rd_n_q;
			end else begin
				out_v_q <= '0;
				out_n_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign value_sum   = out_v_q;
	assign norm_sum    = out_n_q;
endmodule
`default_nettype wire
